FILE: design/multi_checksum_engine_defines.svh
// ---------------------------------------------------------------------------
// Checksum engine assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and off in reset.
// ---------------------------------------------------------------------------
`ifndef MULTI_CHECKSUM_ENGINE_DEFINES_SVH
`define MULTI_CHECKSUM_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MCE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("checksum engine check failed");

// Next-cycle implication.
`define MCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("checksum engine check failed");

`else

`define MCE_ASSERT_IMPL(label, ante, cons)
`define MCE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: design/mce_pkg.sv
// ---------------------------------------------------------------------------
// Checksum engine package
// Types, constants and byte-step functions shared by the engine modules.
// ---------------------------------------------------------------------------
package mce_pkg;

  // Input item modes
  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINAL  = 1'b1;

  // Register index (word address bit)
  localparam logic REG_DIGEST_EN = 1'b0;
  localparam logic [3:0] DIGEST_EN_RESET = 4'hF;

  // Enable bit positions
  localparam int unsigned EN_CKSUM  = 0;
  localparam int unsigned EN_CRC32  = 1;
  localparam int unsigned EN_CRC32C = 2;
  localparam int unsigned EN_ADLER  = 3;

  localparam logic [31:0] POLY_CKSUM  = 32'h04C1_1DB7;
  localparam logic [31:0] POLY_CRC32  = 32'hEDB8_8320;
  localparam logic [31:0] POLY_CRC32C = 32'h82F6_3B78;
  localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;
  localparam logic [16:0] ADLER_MOD   = 17'd65521;

  typedef enum logic {
    ST_RUN,
    ST_WALK
  } mce_state_e;

  // Controller to datapath
  typedef struct packed {
    logic absorb;
    logic start;
    logic step;
    logic finish;
  } mce_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_zero;
  } mce_sts_t;

  // MSB-first CRC-32 over one byte.
  function automatic logic [31:0] msb_crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ POLY_CKSUM) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

  // Reflected CRC-32 over one byte.
  function automatic logic [31:0] lsb_crc_byte(logic [31:0] crc, logic [7:0] b,
                                               logic [31:0] poly);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ({1'b0, c[31:1]} ^ poly) : {1'b0, c[31:1]};
    end
    return c;
  endfunction

  // Reduce a value below twice the Adler modulus.
  function automatic logic [15:0] adler_fold(logic [16:0] v);
    logic [16:0] r;
    r = (v >= ADLER_MOD) ? (v - ADLER_MOD) : v;
    return r[15:0];
  endfunction

endpackage

FILE: design/mce_datapath.sv
// ---------------------------------------------------------------------------
// Checksum engine datapath
// Running checksums, byte counter, length walk and output registers.
// ---------------------------------------------------------------------------
module mce_datapath #(
  parameter int unsigned COUNT_BITS = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mce_pkg::mce_cmd_t cmd_i,
  output mce_pkg::mce_sts_t sts_o,
  input  logic [7:0]        data_byte_i,
  input  logic [3:0]        enable_i,
  output logic [31:0]       cksum_value_o,
  output logic [31:0]       crc32_value_o,
  output logic [31:0]       crc32c_value_o,
  output logic [31:0]       adler32_value_o,
  output logic [39:0]       byte_count_o,
  output logic              count_overflow_o
);

  logic [31:0]           cksum_q, cksum_d;
  logic [31:0]           crc32_q, crc32_d;
  logic [31:0]           crc32c_q, crc32c_d;
  logic [15:0]           sum1_q, sum1_d;
  logic [15:0]           sum2_q, sum2_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  ovf_q, ovf_d;
  logic [COUNT_BITS-1:0] walk_cnt_q, walk_cnt_d;
  logic [31:0]           walk_crc_q, walk_crc_d;
  logic [15:0]           sum1_new;
  logic [63:0]           count_ext;

  logic [31:0] cksum_out_q, crc32_out_q, crc32c_out_q, adler_out_q;
  logic [39:0] total_out_q;
  logic        ovf_out_q;

  assign sum1_new  = mce_pkg::adler_fold({1'b0, sum1_q} + {9'b0, data_byte_i});
  assign count_ext = 64'(count_q);

  always_comb begin
    cksum_d    = cksum_q;
    crc32_d    = crc32_q;
    crc32c_d   = crc32c_q;
    sum1_d     = sum1_q;
    sum2_d     = sum2_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    walk_cnt_d = walk_cnt_q;
    walk_crc_d = walk_crc_q;
    if (cmd_i.absorb) begin
      if (count_q == {COUNT_BITS{1'b1}}) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
      end
      if (enable_i[mce_pkg::EN_CKSUM]) begin
        cksum_d = mce_pkg::msb_crc_byte(cksum_q, data_byte_i);
      end
      if (enable_i[mce_pkg::EN_CRC32]) begin
        crc32_d = mce_pkg::lsb_crc_byte(crc32_q, data_byte_i, mce_pkg::POLY_CRC32);
      end
      if (enable_i[mce_pkg::EN_CRC32C]) begin
        crc32c_d = mce_pkg::lsb_crc_byte(crc32c_q, data_byte_i, mce_pkg::POLY_CRC32C);
      end
      if (enable_i[mce_pkg::EN_ADLER]) begin
        sum1_d = sum1_new;
        sum2_d = mce_pkg::adler_fold({1'b0, sum2_q} + {1'b0, sum1_new});
      end
    end
    if (cmd_i.start) begin
      walk_cnt_d = count_q;
      walk_crc_d = cksum_q;
    end
    if (cmd_i.step) begin
      walk_crc_d = mce_pkg::msb_crc_byte(walk_crc_q, walk_cnt_q[7:0]);
      walk_cnt_d = walk_cnt_q >> 8;
    end
    if (cmd_i.finish) begin
      // re-initialise for the next file
      cksum_d  = '0;
      crc32_d  = mce_pkg::CRC_ONES;
      crc32c_d = mce_pkg::CRC_ONES;
      sum1_d   = 16'd1;
      sum2_d   = '0;
      count_d  = '0;
      ovf_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cksum_q  <= '0;
      crc32_q  <= mce_pkg::CRC_ONES;
      crc32c_q <= mce_pkg::CRC_ONES;
      sum1_q   <= 16'd1;
      sum2_q   <= '0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
    end else begin
      cksum_q  <= cksum_d;
      crc32_q  <= crc32_d;
      crc32c_q <= crc32c_d;
      sum1_q   <= sum1_d;
      sum2_q   <= sum2_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_cnt_q <= walk_cnt_d;
    walk_crc_q <= walk_crc_d;
    if (cmd_i.finish) begin
      cksum_out_q  <= enable_i[mce_pkg::EN_CKSUM]  ? ~walk_crc_q : '0;
      crc32_out_q  <= enable_i[mce_pkg::EN_CRC32]  ? ~crc32_q : '0;
      crc32c_out_q <= enable_i[mce_pkg::EN_CRC32C] ? (crc32c_q ^ mce_pkg::CRC_ONES) : '0;
      adler_out_q  <= enable_i[mce_pkg::EN_ADLER]  ? {sum2_q, sum1_q} : '0;
      total_out_q  <= count_ext[39:0];
      ovf_out_q    <= ovf_q;
    end
  end

  assign sts_o.walk_zero = (walk_cnt_q == '0);

  assign cksum_value_o    = cksum_out_q;
  assign crc32_value_o    = crc32_out_q;
  assign crc32c_value_o   = crc32c_out_q;
  assign adler32_value_o  = adler_out_q;
  assign byte_count_o     = total_out_q;
  assign count_overflow_o = ovf_out_q;

endmodule

FILE: design/mce_ctrl.sv
// ---------------------------------------------------------------------------
// Checksum engine controller
// Sequences absorb, length walk and result hand-off.
// ---------------------------------------------------------------------------
`include "multi_checksum_engine_defines.svh"

module mce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_mode_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mce_pkg::mce_cmd_t cmd_o,
  input  mce_pkg::mce_sts_t sts_i
);

  mce_pkg::mce_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_blocked;

  assign out_blocked = out_valid_q && out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      mce_pkg::ST_RUN: begin
        if (in_valid_i) begin
          if (in_mode_i == mce_pkg::MODE_FINAL) begin
            cmd_o.start = 1'b1;
            state_d     = mce_pkg::ST_WALK;
          end else begin
            cmd_o.absorb = 1'b1;
          end
        end
      end
      mce_pkg::ST_WALK: begin
        if (!sts_i.walk_zero) begin
          cmd_o.step = 1'b1;
        end else if (!out_blocked) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = mce_pkg::ST_RUN;
        end
      end
      default: begin
        state_d = mce_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mce_pkg::ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != mce_pkg::ST_RUN);
  assign out_valid_o = out_valid_q;

  `MCE_ASSERT_NEXT(a_final_enters_walk, in_valid_i && !in_stall_o && in_mode_i == mce_pkg::MODE_FINAL, state_q == mce_pkg::ST_WALK)
  `MCE_ASSERT_IMPL(a_finish_after_walk, cmd_o.finish, sts_i.walk_zero)
  `MCE_ASSERT_IMPL(a_finish_not_blocked, cmd_o.finish, !out_blocked)
  `MCE_ASSERT_NEXT(a_finish_shows_result, cmd_o.finish, out_valid_q)

endmodule

FILE: design/multi_checksum_engine.sv
// ---------------------------------------------------------------------------
// Multi checksum engine: POSIX cksum, CRC-32, CRC-32C, Adler-32 and count
// Data bytes: one transfer per cycle unless in_stall_o, no result. Finalise: the
// count is walked into cksum, one step per significant byte (0..COUNT_BITS/8);
// results then register; input stalls during the walk, longer while a result is held.
// Reset (async, active low): enables all ones, checksums at init, no result pending.
// ---------------------------------------------------------------------------
module multi_checksum_engine #(
  parameter int unsigned COUNT_BITS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] cksum_value_o,
  output logic [31:0] crc32_value_o,
  output logic [31:0] crc32c_value_o,
  output logic [31:0] adler32_value_o,
  output logic [39:0] byte_count_o,
  output logic        count_overflow_o
);

  // The length walk of a finalize runs through the shared MSB-first CRC
  // byte step, one count byte per cycle, least significant first, until the
  // remaining count is zero. The result register sits after the walk, so
  // data bytes of the next file may flow while a result waits; a following
  // finalize holds at the end of its walk until the result is taken.

  logic [3:0]        enable_q;
  mce_pkg::mce_cmd_t cmd;
  mce_pkg::mce_sts_t sts;

  // Digest enable register: one word, decoded on the word address bit.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= mce_pkg::DIGEST_EN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == mce_pkg::REG_DIGEST_EN) begin
      enable_q <= pwdata[3:0];
    end
  end

  // Read back the enables; other addresses read zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == mce_pkg::REG_DIGEST_EN) begin
      prdata = {28'h0, enable_q};
    end
  end

  // Sequencer: absorb, length walk, result hand-off
  mce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_mode_i   (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Checksum state, counter and result registers
  mce_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .data_byte_i      (data_byte_i),
    .enable_i         (enable_q),
    .cksum_value_o    (cksum_value_o),
    .crc32_value_o    (crc32_value_o),
    .crc32c_value_o   (crc32c_value_o),
    .adler32_value_o  (adler32_value_o),
    .byte_count_o     (byte_count_o),
    .count_overflow_o (count_overflow_o)
  );

endmodule
